// ===== hw/rtl/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
`default_nettype none

package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int CELL_W       = ATTR_W + CHAR_W;
  localparam int IDX_W        = 11;
  localparam int CURSOR_ROW_W = 5;
  localparam int CURSOR_COL_W = 7;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]       cell_data;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CURSOR_COL_W-1:0] cursor_column;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic sweep_step;
    logic sweep_boot;
    logic load_out;
  } tcce_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic sweep_last;
  } tcce_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcce_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_ctrl.sv =====
// Controller state machine for the text console cursor engine.
`default_nettype none

module tcce_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tcce_pkg::tcce_cmd_t        cmd,
  input  wire tcce_pkg::tcce_status_t status
);

  import tcce_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) || ((state == ST_FINISH) && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load_item  = accept;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_boot = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_dp.sv =====
// Datapath: cursor, ring-buffer screen addressing, clear sweeps and result register.
`default_nettype none

module tcce_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcce_pkg::in_item_t         in_data,
  input  wire logic                       cfg_write_en,
  input  wire logic [tcce_pkg::ATTR_W-1:0] cfg_write_data,
  input  wire tcce_pkg::tcce_cmd_t        cmd,
  output tcce_pkg::tcce_status_t          status,
  output tcce_pkg::out_item_t             out_data
);

  import tcce_pkg::*;

  function automatic logic [ADDR_W-1:0] line_advance(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W+1)'(COLUMNS);
    if (s >= (ADDR_W+1)'(CELL_COUNT)) begin
      s = s - (ADDR_W+1)'(CELL_COUNT);
    end
    return s[ADDR_W-1:0];
  endfunction

  in_item_t          item;
  logic [ATTR_W-1:0] attr;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] line;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] cnt;

  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] line_next;
  logic [ADDR_W-1:0] base_next;

  logic [COL_W:0]    col_p1;
  logic [COL_W:0]    tab_col;
  logic              newline;
  logic              wr_char;
  logic              in_range;
  logic [ADDR_W:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CELL_W-1:0] ram_rdata;

  assign col_p1   = {1'b0, col} + (COL_W+1)'(1);
  assign tab_col  = ({1'b0, col} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
  assign in_range = {1'b0, item.cell_index} < (IDX_W+1)'(CELL_COUNT);

  always_comb begin
    newline  = 1'b0;
    wr_char  = 1'b0;
    col_next = col;
    case (item.char_code)
      CH_NEWLINE: begin
        newline = 1'b1;
      end
      CH_RETURN: begin
        col_next = '0;
      end
      CH_TAB: begin
        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
          newline = 1'b1;
        end else begin
          col_next = tab_col[COL_W-1:0];
        end
      end
      default: begin
        wr_char = 1'b1;
        if (col_p1 >= (COL_W+1)'(COLUMNS)) begin
          newline = 1'b1;
        end else begin
          col_next = col_p1[COL_W-1:0];
        end
      end
    endcase
  end

  always_comb begin
    row_next  = row;
    line_next = line;
    base_next = base;
    if (newline) begin
      line_next = line_advance(line);
      if (row == ROW_W'(ROWS - 1)) begin
        base_next = line_advance(base);
      end else begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  assign status.need_scroll = (item.req_type == REQ_PUT) && newline &&
                              (row == ROW_W'(ROWS - 1));
  assign status.sweep_last  = cmd.sweep_boot ? (cnt == ADDR_W'(CELL_COUNT - 1))
                                             : (cnt == ADDR_W'(COLUMNS - 1));

  always_comb begin
    rd_sum = (ADDR_W+1)'(item.cell_index) + {1'b0, base};
    if (rd_sum >= (ADDR_W+1)'(CELL_COUNT)) begin
      rd_sum = rd_sum - (ADDR_W+1)'(CELL_COUNT);
    end
    rd_addr = rd_sum[ADDR_W-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = line + ADDR_W'(col);
    ram_wdata = {attr, item.char_code};
    if (cmd.sweep_step) begin
      ram_we = 1'b1;
      if (cmd.sweep_boot) begin
        ram_waddr = cnt;
        ram_wdata = RESET_CELL;
      end else begin
        ram_waddr = line + cnt;
        ram_wdata = {attr, CH_SPACE};
      end
    end else if (cmd.exec && (item.req_type == REQ_PUT) && wr_char) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = cmd.exec && (item.req_type == REQ_READ) && in_range;

  tcce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.load_out) begin
      out_data.cell_data     <= ((item.req_type == REQ_READ) && in_range) ? ram_rdata : '0;
      out_data.cursor_row    <= CURSOR_ROW_W'(row);
      out_data.cursor_column <= CURSOR_COL_W'(col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
      row  <= '0;
      col  <= '0;
      line <= '0;
      base <= '0;
      cnt  <= '0;
    end else begin
      if (cfg_write_en) begin
        attr <= cfg_write_data;
      end
      if (cmd.exec && (item.req_type == REQ_PUT)) begin
        row  <= row_next;
        col  <= newline ? '0 : col_next;
        line <= line_next;
        base <= base_next;
      end
      if (cmd.sweep_step) begin
        cnt <= status.sweep_last ? '0 : cnt + ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cursor_engine_top.sv =====
// Top level of the text console cursor engine.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid / in_stall     in_data (in_item_t)
//  out       output     out_valid / out_stall   out_data (out_item_t)
//  cfg       input      cfg_write_en            cfg_write_data (text attribute)
//
// An item passes through an execute state and then a finish state, which waits until the result side is free.
// A put that scrolls adds a sweep that blanks the new bottom line; the
// screen is a ring of lines, so scrolling moves a base pointer, not cells.
// After reset a clearing pass over all ROWS*COLUMNS cells blanks the screen
// memory; no item is taken until it ends.
// A stalled result holds in the output register while the next item is taken.
`default_nettype none

module text_console_cursor_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire tcce_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output tcce_pkg::out_item_t              out_data,
  input  wire logic                        cfg_write_en,
  input  wire logic [tcce_pkg::ATTR_W-1:0] cfg_write_data
);

  import tcce_pkg::*;

  tcce_cmd_t    cmd;
  tcce_status_t status;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tcce_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_data       (in_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .cmd           (cmd),
    .status        (status),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tcce_screen_checker.sv =====
`timescale 1ns / 100ps
// Screen and cursor predictor and result checker for the text console cursor engine.
module tcce_screen_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  tcce_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tcce_pkg::out_item_t           out_data,
  input  logic                          cfg_write_en,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_write_data,
  output int                            error_count,
  output int                            reports_due_count,
  output int                            reports_checked
);

  import tcce_pkg::*;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] attr;
  out_item_t         reports_due [$];

  task automatic advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) screen[(ROWS - 1) * COLUMNS + c] = {attr, CH_SPACE};
      cur_row = ROWS - 1;
    end
  endtask

  task automatic predict_report(input in_item_t req, output out_item_t rep);
    rep = '0;
    if (req.req_type == REQ_PUT) begin
      case (req.char_code)
        CH_NEWLINE: advance_line();
        CH_RETURN: cur_col = 0;
        CH_TAB: begin
          cur_col = (cur_col + 8) & ~32'd7;
          if (cur_col >= COLUMNS) advance_line();
        end
        default: begin
          screen[cur_row * COLUMNS + cur_col] = {attr, req.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) advance_line();
        end
      endcase
    end else if (req.cell_index < CELL_COUNT) begin
      rep.cell_data = screen[req.cell_index];
    end
    rep.cursor_row    = cur_row[CURSOR_ROW_W-1:0];
    rep.cursor_column = cur_col[CURSOR_COL_W-1:0];
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) screen[i] = RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      attr = RESET_ATTR;
      reports_due.delete();
      error_count = 0;
      reports_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          if (out_data.cell_data !== want.cell_data) begin
            $display("%0t: cell_data mismatch, expected %h, actual %h",
                     $time, want.cell_data, out_data.cell_data);
            error_count++;
          end
          if (out_data.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row mismatch, expected %0d, actual %0d",
                     $time, want.cursor_row, out_data.cursor_row);
            error_count++;
          end
          if (out_data.cursor_column !== want.cursor_column) begin
            $display("%0t: cursor_column mismatch, expected %0d, actual %0d",
                     $time, want.cursor_column, out_data.cursor_column);
            error_count++;
          end
        end
      end
      if (cfg_write_en) attr = cfg_write_data;
      if (in_valid && !in_stall) begin
        predict_report(in_data, want);
        reports_due.push_back(want);
      end
    end
    reports_due_count = reports_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives put and read requests and attribute writes, and reports the verdict.
module tb;
  import tcce_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_write_en;
  logic [ATTR_W-1:0] cfg_write_data;
  int                error_count;
  int                reports_due_count;
  int                reports_checked;
  bit                steady;
  int                puts_sent;
  int                reads_sent;
  int                attr_settings;

  localparam int QUIET_CYCLES = COLUMNS + 20;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;

  text_console_cursor_engine_top u_dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .cfg_write_en,
    .cfg_write_data
  );

  tcce_screen_checker u_checker (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .cfg_write_en,
    .cfg_write_data,
    .error_count,
    .reports_due_count,
    .reports_checked
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 24);
  end

  function automatic in_item_t put_req(input logic [CHAR_W-1:0] ch);
    in_item_t req;
    req.req_type   = REQ_PUT;
    req.char_code  = ch;
    req.cell_index = IDX_W'($urandom_range(0, IDX_MAX));
    return req;
  endfunction

  function automatic in_item_t read_req(input int unsigned idx);
    in_item_t req;
    req.req_type   = REQ_READ;
    req.char_code  = CHAR_W'($urandom_range(0, 255));
    req.cell_index = IDX_W'(idx);
    return req;
  endfunction

  function automatic in_item_t random_req();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      k = $urandom_range(0, 99);
      if (k < 10) return put_req(CH_NEWLINE);
      if (k < 15) return put_req(CH_RETURN);
      if (k < 23) return put_req(CH_TAB);
      return put_req(CHAR_W'($urandom_range(0, 255)));
    end
    k = $urandom_range(0, 99);
    if (k < 40) return read_req($urandom_range((ROWS - 5) * COLUMNS, CELL_COUNT - 1));
    if (k < 80) return read_req($urandom_range(0, CELL_COUNT - 1));
    return read_req($urandom_range(CELL_COUNT, IDX_MAX));
  endfunction

  task automatic send_request(input in_item_t req);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    if (req.req_type == REQ_PUT) puts_sent++;
    else reads_sent++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    in_valid <= 1'b0;
    while (reports_due_count != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    attr_settings++;
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    steady         = 1'b0;
    puts_sent      = 0;
    reads_sent     = 0;
    attr_settings  = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(read_req(0));
    send_request(read_req(CELL_COUNT - 1));
    send_request(read_req(CELL_COUNT));
    send_request(read_req(IDX_MAX));
    send_request(put_req(8'd65));
    send_request(put_req(8'h00));
    send_request(put_req(8'hFF));
    send_request(put_req(8'd1));
    send_request(put_req(8'd27));
    send_request(read_req(0));
    send_request(read_req(4));
    send_request(put_req(CH_RETURN));
    send_request(put_req(CH_TAB));
    send_request(put_req(CH_NEWLINE));
    repeat (10) send_request(put_req(CH_TAB));
    send_request(read_req(COLUMNS));

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        case (p)
          1: phase_attr = 8'h00;
          2: phase_attr = 8'hFF;
          default: phase_attr = ATTR_W'($urandom_range(0, 255));
        endcase
        set_attribute(phase_attr);
      end
      steady <= (p == 3);
      repeat (200) send_request(random_req());
    end

    in_valid <= 1'b0;
    while (reports_due_count != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("Sent %0d puts and %0d reads under %0d text attributes, %0d results checked",
             puts_sent, reads_sent, attr_settings, reports_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/tcce_dp.sv
hw/rtl/text_console_cursor_engine_top.sv
tb/sv/tcce_screen_checker.sv
tb/sv/tb.sv
